### hw/rtl/hmfp_pkg.sv
// Package for the HDR metadata frame parser: parse phases, result codes,
// the result record and the configuration record. No dependencies.
`default_nettype none

package hmfp_pkg;

  // Most frames one packet may hold.
  localparam int unsigned MaxFrames = 16;
  localparam int unsigned FrameCountW = 5;

  // Depth of the result queue.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW = $clog2(ResDepth);
  localparam int unsigned ResCntW = $clog2(ResDepth + 1);

  // Field counts and widths of the two known frame types.
  localparam logic [3:0] TypeOneFields = 4'd10;
  localparam logic [3:0] TypeTwoFields = 4'd2;
  localparam logic [3:0] TypeOneShortFields = 4'd8;
  localparam logic [7:0] ShortFieldBytes = 8'd2;
  localparam logic [7:0] LongFieldBytes = 8'd4;
  localparam logic [7:0] SeiBytes = 8'd2;
  localparam logic [7:0] MinFrameLength = 8'd2;

  // Configuration register indexes.
  localparam logic [0:0] RegStaticOneType = 1'b0;
  localparam logic [0:0] RegStaticTwoType = 1'b1;

  // Result kinds.
  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindField = 2'd1;
  localparam logic [1:0] KindEnd = 2'd2;

  // Packet status codes.
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusHeaderTrunc = 2'd1;
  localparam logic [1:0] StatusBodyTrunc = 2'd2;
  localparam logic [1:0] StatusTableFull = 2'd3;

  typedef enum logic [2:0] {
    PhIdle,
    PhType,
    PhLen,
    PhSei,
    PhFields,
    PhSkip,
    PhDiscard
  } phase_e;

  typedef struct packed {
    logic [7:0] static_one_type;
    logic [7:0] static_two_type;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [3:0]             frame_index;
    logic [7:0]             type_byte;
    logic [7:0]             len_byte;
    logic [3:0]             field_index;
    logic [31:0]            field_value;
    logic [FrameCountW-1:0] frame_count;
    logic [1:0]             parse_status;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/hmfp_core.sv
// Parser state and the per-byte step logic of the HDR metadata frame parser.
// Uses hmfp_pkg; produces up to two result records per accepted beat.
`default_nettype none

module hmfp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             packet_start_i,
  input  wire logic [7:0]       packet_length_i,
  input  wire hmfp_pkg::cfg_t   cfg_i,
  output hmfp_pkg::result_t     res0_o,
  output hmfp_pkg::result_t     res1_o,
  output logic [1:0]            res_cnt_o
);

  hmfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  rem_q, rem_d;
  logic [hmfp_pkg::FrameCountW-1:0] frames_q, frames_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  bif_q, bif_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  status_q, status_d;
  logic        known_one_q, known_one_d;

  logic        process;
  logic        prim_vld, end_vld;
  logic [7:0]  eff_len;
  logic [7:0]  need_bytes;
  logic [3:0]  last_field;
  logic [hmfp_pkg::FrameCountW-1:0] frame_idx;
  hmfp_pkg::result_t prim_res, end_res;

  // Next state and results of one payload byte.
  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    frames_d    = frames_q;
    type_d      = type_q;
    len_d       = len_q;
    fcnt_d      = fcnt_q;
    bif_d       = bif_q;
    acc_d       = acc_q;
    status_d    = status_q;
    known_one_d = known_one_q;
    process     = 1'b0;
    prim_vld    = 1'b0;
    end_vld     = 1'b0;
    eff_len     = '0;
    need_bytes  = hmfp_pkg::ShortFieldBytes;
    last_field  = hmfp_pkg::TypeTwoFields;
    frame_idx   = '0;
    prim_res    = '0;
    end_res     = '0;

    if (step_i) begin
      if (packet_start_i) begin
        // A start word opens a new packet and abandons any open one.
        phase_d     = hmfp_pkg::PhType;
        rem_d       = packet_length_i;
        frames_d    = '0;
        type_d      = '0;
        len_d       = '0;
        fcnt_d      = '0;
        bif_d       = '0;
        acc_d       = '0;
        status_d    = hmfp_pkg::StatusOk;
        known_one_d = 1'b0;
        if (packet_length_i == 8'd0) begin
          phase_d = hmfp_pkg::PhIdle;
          end_vld = 1'b1;
        end else begin
          process = 1'b1;
        end
      end else if (phase_q == hmfp_pkg::PhIdle || rem_q == 8'd0) begin
        phase_d = hmfp_pkg::PhIdle;
      end else begin
        process = 1'b1;
      end
    end

    if (process) begin
      case (phase_d)
        hmfp_pkg::PhType: begin
          if (frames_d >= hmfp_pkg::FrameCountW'(hmfp_pkg::MaxFrames)) begin
            status_d = hmfp_pkg::StatusTableFull;
            phase_d  = hmfp_pkg::PhDiscard;
          end else if (rem_d < 8'd2) begin
            status_d = hmfp_pkg::StatusHeaderTrunc;
            phase_d  = hmfp_pkg::PhDiscard;
          end else begin
            type_d  = data_byte_i;
            phase_d = hmfp_pkg::PhLen;
          end
        end
        hmfp_pkg::PhLen: begin
          eff_len = (data_byte_i < hmfp_pkg::MinFrameLength) ?
                    hmfp_pkg::MinFrameLength : data_byte_i;
          len_d = data_byte_i;
          if ((rem_d - 8'd1) < eff_len) begin
            status_d = hmfp_pkg::StatusBodyTrunc;
            phase_d  = hmfp_pkg::PhDiscard;
          end else begin
            frames_d = frames_d + 1'b1;
            prim_vld = 1'b1;
            prim_res.kind = hmfp_pkg::KindHeader;
            bif_d    = '0;
            phase_d  = hmfp_pkg::PhSei;
          end
        end
        hmfp_pkg::PhSei: begin
          bif_d = bif_d + 8'd1;
          if (bif_d >= hmfp_pkg::SeiBytes) begin
            bif_d  = '0;
            fcnt_d = '0;
            acc_d  = '0;
            if (type_d == cfg_i.static_one_type) begin
              known_one_d = 1'b1;
              phase_d     = hmfp_pkg::PhFields;
            end else if (type_d == cfg_i.static_two_type) begin
              known_one_d = 1'b0;
              phase_d     = hmfp_pkg::PhFields;
            end else begin
              // Unknown type: skip the rest of the body.
              eff_len = (len_d < hmfp_pkg::MinFrameLength) ?
                        hmfp_pkg::MinFrameLength : len_d;
              bif_d   = eff_len - hmfp_pkg::SeiBytes;
              phase_d = (bif_d == 8'd0) ? hmfp_pkg::PhType : hmfp_pkg::PhSkip;
            end
          end
        end
        hmfp_pkg::PhFields: begin
          acc_d = {acc_d[23:0], data_byte_i};
          bif_d = bif_d + 8'd1;
          if (known_one_d && fcnt_d >= hmfp_pkg::TypeOneShortFields) begin
            need_bytes = hmfp_pkg::LongFieldBytes;
          end
          last_field = known_one_d ? hmfp_pkg::TypeOneFields : hmfp_pkg::TypeTwoFields;
          if (bif_d >= need_bytes) begin
            prim_vld = 1'b1;
            prim_res.kind        = hmfp_pkg::KindField;
            prim_res.field_index = fcnt_d;
            prim_res.field_value = acc_d;
            fcnt_d = fcnt_d + 4'd1;
            bif_d  = '0;
            acc_d  = '0;
            if (fcnt_d >= last_field) begin
              fcnt_d  = '0;
              phase_d = hmfp_pkg::PhType;
            end
          end
        end
        hmfp_pkg::PhSkip: begin
          if (bif_d != 8'd0) begin
            bif_d = bif_d - 8'd1;
          end
          if (bif_d == 8'd0) begin
            phase_d = hmfp_pkg::PhType;
          end
        end
        default: begin
        end
      endcase

      // Header and field records carry the current frame.
      frame_idx            = frames_d - 1'b1;
      prim_res.frame_index = frame_idx[3:0];
      prim_res.type_byte   = type_d;
      prim_res.len_byte    = len_d;

      // The last byte of the packet closes it.
      rem_d = rem_d - 8'd1;
      if (rem_d == 8'd0) begin
        if (status_d == hmfp_pkg::StatusOk &&
            (phase_d == hmfp_pkg::PhFields || phase_d == hmfp_pkg::PhSei ||
             phase_d == hmfp_pkg::PhSkip || phase_d == hmfp_pkg::PhLen)) begin
          status_d = hmfp_pkg::StatusBodyTrunc;
        end
        end_vld = 1'b1;
        phase_d = hmfp_pkg::PhIdle;
      end
    end

    end_res.kind         = hmfp_pkg::KindEnd;
    end_res.frame_count  = process ? frames_d : '0;
    end_res.parse_status = process ? status_d : hmfp_pkg::StatusOk;
    end_res.last         = 1'b1;
  end

  // Primary record goes first; the end record follows it.
  assign res0_o    = prim_vld ? prim_res : end_res;
  assign res1_o    = end_res;
  assign res_cnt_o = {1'b0, prim_vld} + {1'b0, end_vld};

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hmfp_pkg::PhIdle;
      rem_q       <= '0;
      frames_q    <= '0;
      type_q      <= '0;
      len_q       <= '0;
      fcnt_q      <= '0;
      bif_q       <= '0;
      acc_q       <= '0;
      status_q    <= hmfp_pkg::StatusOk;
      known_one_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      frames_q    <= frames_d;
      type_q      <= type_d;
      len_q       <= len_d;
      fcnt_q      <= fcnt_d;
      bif_q       <= bif_d;
      acc_q       <= acc_d;
      status_q    <= status_d;
      known_one_q <= known_one_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hmfp_result_fifo.sv
// Result queue of the HDR metadata frame parser: takes up to two records
// per cycle and hands out one per beat. Uses hmfp_pkg.
`default_nettype none

module hmfp_result_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hmfp_pkg::result_t push0_i,
  input  wire hmfp_pkg::result_t push1_i,
  input  wire logic [1:0]        push_cnt_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output hmfp_pkg::result_t      head_o
);

  hmfp_pkg::result_t entries_q [hmfp_pkg::ResDepth];
  logic [hmfp_pkg::ResPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hmfp_pkg::ResCntW-1:0] count_q, count_d;
  logic [hmfp_pkg::ResPtrW-1:0] wr_ptr_nx;
  logic pop;

  assign pop       = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign valid_o   = (count_q != '0);
  assign head_o    = entries_q[rd_ptr_q];
  // Room for two records so that a beat can always be taken in full.
  assign room_o    = (count_q <= hmfp_pkg::ResCntW'(hmfp_pkg::ResDepth - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + hmfp_pkg::ResPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + hmfp_pkg::ResPtrW'(pop);
    count_d  = count_q + hmfp_pkg::ResCntW'(push_cnt_i) - hmfp_pkg::ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entries_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entries_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hdr_metadata_frame_parser.sv
// HDR metadata frame parser, top level: stream ports, configuration
// registers, step logic (hmfp_core) and result queue (hmfp_result_fifo).
//
// The parser takes one payload word per clock and finishes it in that cycle;
// its results go into a four-entry queue that drives the output stream. Most
// words give zero or one result; a packet's last word can give two (a field
// record followed by the end record), taking two output beats. s_axis_tready
// drops only while the queue holds more than two records, so with the output
// taking a beat every cycle the input runs at one word per clock. The user
// must write type codes through the configuration channel while the stream
// is idle; the block does not enforce this. No clearing pass after reset.
`default_nettype none

module hdr_metadata_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Payload input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // data_word[9:0], packet_length[17:10]
  input  wire logic        s_axis_tuser,  // packet_start
  // Result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // frame_index[3:0], type_byte[11:4],
                                          // len_byte[19:12], field_index[23:20],
                                          // field_value[55:24], frame_count[60:56],
                                          // parse_status[62:61]
  output logic [1:0]       m_axis_tuser,  // result_kind
  output logic             m_axis_tlast,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  hmfp_pkg::cfg_t    cfg_q;
  hmfp_pkg::result_t res0, res1, head;
  logic [1:0]        res_cnt;
  logic              room;
  logic              in_beat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.static_one_type <= 8'd0;
      cfg_q.static_two_type <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hmfp_pkg::RegStaticOneType: cfg_q.static_one_type <= cfg_data_i;
        hmfp_pkg::RegStaticTwoType: cfg_q.static_two_type <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  hmfp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_beat),
    .data_byte_i     (s_axis_tdata[7:0]),
    .packet_start_i  (s_axis_tuser),
    .packet_length_i (s_axis_tdata[17:10]),
    .cfg_i           (cfg_q),
    .res0_o          (res0),
    .res1_o          (res1),
    .res_cnt_o       (res_cnt)
  );

  hmfp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (res0),
    .push1_i    (res1),
    .push_cnt_i (res_cnt),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .pop_i      (m_axis_tready),
    .head_o     (head)
  );

  // Output beat packing.
  assign m_axis_tdata = {1'b0, head.parse_status, head.frame_count, head.field_value,
                         head.field_index, head.len_byte, head.type_byte,
                         head.frame_index};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // Input backpressure only comes from queued results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result queue");

  // A zero-length start word yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tuser && s_axis_tdata[17:10] == 8'd0) |=> m_axis_tvalid)
    else $error("zero-length packet gave no end result");

  // End records and only end records close a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == hmfp_pkg::KindEnd)))
    else $error("tlast does not match the end record");

  // Two records are produced only when the packet ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt == 2'd2) |-> (res1.last && in_beat))
    else $error("double result without end of packet");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for hdr_metadata_frame_parser: a directed table and
// randomized packets, each result beat checked against a frame parse predictor.
// Depends on hmfp_pkg and the hdr_metadata_frame_parser RTL only.

module tb_top;
  import hmfp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongStall = 300;

  // One directed stimulus row; typed rows carry their expected result.
  typedef struct packed {
    logic [9:0] word;
    logic       start;
    logic [7:0] plen;
    logic       typed;
    logic [1:0] n;
    result_t    r;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  // Predictor copy of the configuration and parse state.
  logic [7:0]  code_one = 8'd0;
  logic [7:0]  code_two = 8'd1;
  phase_e      parse_ph = PhIdle;
  logic [7:0]  bytes_left = '0;
  logic [4:0]  frames_acc = '0;
  logic [7:0]  cur_type = '0;
  logic [7:0]  cur_len = '0;
  logic [3:0]  fld_cnt = '0;
  logic [7:0]  fld_byte = '0;
  logic [31:0] fld_acc = '0;
  logic [1:0]  pkt_status = StatusOk;
  logic        is_one = 1'b0;

  result_t     word_results[$];
  result_t     results_due[$];
  vector_t     directed_rows[25];

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          stall_request = 1'b0;

  hdr_metadata_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of 8 time units.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [3:0] fidx,
                                        input logic [7:0] ftype, input logic [7:0] flen,
                                        input logic [3:0] fld, input logic [31:0] val,
                                        input logic [4:0] cnt, input logic [1:0] st,
                                        input logic last);
    result_t r;
    r.kind = kind;
    r.frame_index = fidx;
    r.type_byte = ftype;
    r.len_byte = flen;
    r.field_index = fld;
    r.field_value = val;
    r.frame_count = cnt;
    r.parse_status = st;
    r.last = last;
    return r;
  endfunction

  function automatic vector_t row(input logic [9:0] w, input logic s, input logic [7:0] l,
                                  input logic typed = 1'b0, input logic [1:0] n = 2'd0,
                                  input result_t r = '0);
    vector_t v;
    v.word = w;
    v.start = s;
    v.plen = l;
    v.typed = typed;
    v.n = n;
    v.r = r;
    return v;
  endfunction

  // Frame parser prediction for one accepted payload word; fills word_results.
  task automatic parse_word(input logic [9:0] word, input logic start, input logic [7:0] plen);
    logic [7:0] b;
    logic [7:0] eff;
    logic [7:0] width;
    logic [4:0] idx;
    b = word[7:0];
    word_results.delete();
    if (start) begin
      parse_ph = PhType;
      bytes_left = plen;
      frames_acc = '0;
      cur_type = '0;
      cur_len = '0;
      fld_cnt = '0;
      fld_byte = '0;
      fld_acc = '0;
      pkt_status = StatusOk;
      is_one = 1'b0;
      if (bytes_left == 8'd0) begin
        parse_ph = PhIdle;
        word_results.push_back(mk_result(KindEnd, 4'd0, 8'd0, 8'd0, 4'd0, 32'd0, 5'd0,
                                         StatusOk, 1'b1));
        return;
      end
    end else if (parse_ph == PhIdle || bytes_left == 8'd0) begin
      parse_ph = PhIdle;
      return;
    end

    case (parse_ph)
      PhType: begin
        if (frames_acc >= 5'(MaxFrames)) begin
          pkt_status = StatusTableFull;
          parse_ph = PhDiscard;
        end else if (bytes_left < 8'd2) begin
          pkt_status = StatusHeaderTrunc;
          parse_ph = PhDiscard;
        end else begin
          cur_type = b;
          parse_ph = PhLen;
        end
      end
      PhLen: begin
        eff = (b < MinFrameLength) ? MinFrameLength : b;
        cur_len = b;
        if (bytes_left - 8'd1 < eff) begin
          pkt_status = StatusBodyTrunc;
          parse_ph = PhDiscard;
        end else begin
          frames_acc = frames_acc + 5'd1;
          idx = frames_acc - 5'd1;
          word_results.push_back(mk_result(KindHeader, idx[3:0], cur_type, cur_len, 4'd0,
                                           32'd0, 5'd0, StatusOk, 1'b0));
          fld_byte = '0;
          parse_ph = PhSei;
        end
      end
      PhSei: begin
        fld_byte = fld_byte + 8'd1;
        if (fld_byte >= SeiBytes) begin
          fld_byte = '0;
          fld_cnt = '0;
          fld_acc = '0;
          // The first type code wins when both registers hold the same code.
          if (cur_type == code_one) begin
            is_one = 1'b1;
            parse_ph = PhFields;
          end else if (cur_type == code_two) begin
            is_one = 1'b0;
            parse_ph = PhFields;
          end else begin
            eff = (cur_len < MinFrameLength) ? MinFrameLength : cur_len;
            fld_byte = eff - SeiBytes;
            parse_ph = (fld_byte == 8'd0) ? PhType : PhSkip;
          end
        end
      end
      PhFields: begin
        fld_acc = {fld_acc[23:0], b};
        fld_byte = fld_byte + 8'd1;
        if (is_one && fld_cnt >= TypeOneShortFields) width = LongFieldBytes;
        else width = ShortFieldBytes;
        if (fld_byte >= width) begin
          idx = frames_acc - 5'd1;
          word_results.push_back(mk_result(KindField, idx[3:0], cur_type, cur_len, fld_cnt,
                                           fld_acc, 5'd0, StatusOk, 1'b0));
          fld_cnt = fld_cnt + 4'd1;
          fld_byte = '0;
          fld_acc = '0;
          if (fld_cnt >= (is_one ? TypeOneFields : TypeTwoFields)) begin
            fld_cnt = '0;
            parse_ph = PhType;
          end
        end
      end
      PhSkip: begin
        if (fld_byte > 8'd0) fld_byte = fld_byte - 8'd1;
        if (fld_byte == 8'd0) parse_ph = PhType;
      end
      default: begin
      end
    endcase

    // The last payload byte closes the packet; an unfinished frame counts as truncated.
    bytes_left = bytes_left - 8'd1;
    if (bytes_left == 8'd0) begin
      if (pkt_status == StatusOk &&
          (parse_ph == PhFields || parse_ph == PhSei || parse_ph == PhSkip ||
           parse_ph == PhLen))
        pkt_status = StatusBodyTrunc;
      word_results.push_back(mk_result(KindEnd, 4'd0, 8'd0, 8'd0, 4'd0, 32'd0, frames_acc,
                                       pkt_status, 1'b1));
      parse_ph = PhIdle;
    end
  endtask

  // Offers one payload word after a random gap and records what it should produce.
  task automatic send_word(input logic [9:0] w, input logic s, input logic [7:0] l,
                           input logic typed = 1'b0, input logic [1:0] n = 2'd0,
                           input result_t r = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, l, w};
    s_axis_tuser <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_word(w, s, l);
    if (typed) begin
      if (n != 2'd0) results_due.push_back(r);
    end else begin
      foreach (word_results[i]) results_due.push_back(word_results[i]);
    end
  endtask

  // Stops the input and waits until every expected beat has arrived.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegStaticOneType) code_one = val;
    else code_two = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Builds one packet of frames with random content and sends it, sometimes
  // cut short, padded, overfilled with frames or abandoned part way.
  task automatic send_packet(output int words);
    logic [7:0] pkt[$];
    logic [7:0] t;
    int         nframes;
    int         flen;
    int         body;
    int         plen;
    int         count;
    int         p;
    bit         known;
    if ($urandom_range(99) < 10) begin
      // One frame more than the table holds, all of a skipped type.
      for (int f = 0; f <= MaxFrames; f++) begin
        do t = 8'($urandom_range(255)); while (t == code_one || t == code_two);
        pkt.push_back(t);
        pkt.push_back(8'd2);
        pkt.push_back(8'($urandom_range(255)));
        pkt.push_back(8'($urandom_range(255)));
      end
    end else begin
      nframes = $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        case ($urandom_range(2))
          0: t = code_one;
          1: t = code_two;
          default: t = 8'($urandom_range(255));
        endcase
        known = (t == code_one) || (t == code_two);
        if (t == code_one) begin
          body = 24;
          flen = 26;
        end else if (t == code_two) begin
          body = 4;
          flen = 6;
        end else begin
          flen = $urandom_range(12);
          body = (flen < 2 ? 2 : flen) - 2;
        end
        if (known && $urandom_range(4) == 0) flen = $urandom_range(flen);
        if (pkt.size() + 4 + body > 255) break;
        pkt.push_back(t);
        pkt.push_back(8'(flen));
        repeat (2 + body) pkt.push_back(8'($urandom_range(255)));
      end
    end

    plen = pkt.size();
    p = $urandom_range(99);
    if (p < 12) begin
      plen = $urandom_range(1, plen);
    end else if (p < 20) begin
      if ($urandom_range(1) == 1) plen = 255;
      else plen = (plen + 4 > 255) ? 255 : plen + $urandom_range(1, 4);
      while (pkt.size() < plen) pkt.push_back(8'($urandom_range(255)));
    end
    count = plen;
    if ($urandom_range(19) == 0 && plen > 1) count = $urandom_range(1, plen - 1);

    for (int i = 0; i < count; i++)
      send_word({2'($urandom_range(3)), pkt[i]}, i == 0,
                (i == 0) ? 8'(plen) : 8'($urandom_range(255)));
    words = count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output side: every accepted beat is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: tuser %0h tdata %0h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("frame_index", 32'(want.frame_index), 32'(m_axis_tdata[3:0]));
        check_field("type_byte", 32'(want.type_byte), 32'(m_axis_tdata[11:4]));
        check_field("len_byte", 32'(want.len_byte), 32'(m_axis_tdata[19:12]));
        check_field("field_index", 32'(want.field_index), 32'(m_axis_tdata[23:20]));
        check_field("field_value", want.field_value, m_axis_tdata[55:24]);
        check_field("frame_count", 32'(want.frame_count), 32'(m_axis_tdata[60:56]));
        check_field("parse_status", 32'(want.parse_status), 32'(m_axis_tdata[62:61]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // Receiver: random back pressure, or one long hold-off when requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        stall_request = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("hdr_metadata_frame_parser test failed");
      $finish;
    end
  end

  // Stimulus: directed table, then six random phases with varied type codes.
  initial begin : stimulus
    logic [7:0] one_codes[6];
    logic [7:0] two_codes[6];
    int         sent;
    int         words;
    bit         paused;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;

    // Reset type codes apply: first code 0, second code 1.
    directed_rows[0] = row(10'h3FF, 1'b0, 8'h00, 1'b1, 2'd0);  // word outside a packet
    directed_rows[1] = row(10'h000, 1'b1, 8'h00, 1'b1, 2'd1,   // zero length packet
                           mk_result(KindEnd, 4'd0, 8'd0, 8'd0, 4'd0, 32'd0, 5'd0,
                                     StatusOk, 1'b1));
    directed_rows[2] = row(10'h3AA, 1'b1, 8'h01, 1'b1, 2'd1,   // short header
                           mk_result(KindEnd, 4'd0, 8'd0, 8'd0, 4'd0, 32'd0, 5'd0,
                                     StatusHeaderTrunc, 1'b1));
    // Short body: length byte 5 with only two bytes left.
    directed_rows[3] = row(10'h005, 1'b1, 8'd3);
    directed_rows[4] = row(10'h005, 1'b0, 8'hFF);
    directed_rows[5] = row(10'h3FF, 1'b0, 8'h00, 1'b1, 2'd1,
                           mk_result(KindEnd, 4'd0, 8'd0, 8'd0, 4'd0, 32'd0, 5'd0,
                                     StatusBodyTrunc, 1'b1));
    // Content light level frame with two fields, last byte also closes the packet.
    directed_rows[6] = row(10'h001, 1'b1, 8'd8);
    directed_rows[7] = row(10'h204, 1'b0, 8'h00);
    directed_rows[8] = row(10'h3FF, 1'b0, 8'hFF);
    directed_rows[9] = row(10'h000, 1'b0, 8'h00);
    directed_rows[10] = row(10'h112, 1'b0, 8'h5A);
    directed_rows[11] = row(10'h034, 1'b0, 8'hA5);
    directed_rows[12] = row(10'h2FF, 1'b0, 8'h00);
    directed_rows[13] = row(10'h3FF, 1'b0, 8'hFF);
    // Longest packet: skipped frame with length 0, then one with one skip byte.
    directed_rows[14] = row(10'h080, 1'b1, 8'hFF);
    directed_rows[15] = row(10'h100, 1'b0, 8'h00);
    directed_rows[16] = row(10'h2AB, 1'b0, 8'h00);
    directed_rows[17] = row(10'h155, 1'b0, 8'h00);
    directed_rows[18] = row(10'h0FF, 1'b0, 8'h00);
    directed_rows[19] = row(10'h003, 1'b0, 8'h00);
    directed_rows[20] = row(10'h300, 1'b0, 8'h00);
    directed_rows[21] = row(10'h0C3, 1'b0, 8'h00);
    directed_rows[22] = row(10'h3C3, 1'b0, 8'h00);
    // Restart mid-packet into a two-byte packet whose frame cannot fit.
    directed_rows[23] = row(10'h0FF, 1'b1, 8'd2);
    directed_rows[24] = row(10'h000, 1'b0, 8'h00);

    one_codes = '{8'h00, 8'hFF, 8'h5A, 8'($urandom_range(255)), 8'h01, 8'($urandom_range(255))};
    two_codes = '{8'hFF, 8'h00, 8'h5A, 8'($urandom_range(255)), 8'h00, 8'($urandom_range(255))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 64;
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].start, directed_rows[i].plen,
                directed_rows[i].typed, directed_rows[i].n, directed_rows[i].r);
    drain_results();

    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      if (ph_i < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 64;
      end else if (ph_i < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(RegStaticOneType, one_codes[ph_i]);
      write_reg(RegStaticTwoType, two_codes[ph_i]);
      // Long output hold-off while the input keeps streaming.
      if (ph_i == 4) stall_request = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < 90) begin
        if (parse_ph == PhIdle && $urandom_range(9) == 0)
          send_word(10'($urandom_range(1023)), 1'b0, 8'($urandom_range(255)));
        send_packet(words);
        sent += words;
        if (ph_i == 1 && !paused && sent >= 45) begin
          drain_results();
          paused = 1'b1;
        end
      end
      // A zero length packet closes anything left open.
      send_word(10'($urandom_range(1023)), 1'b1, 8'd0);
      drain_results();
    end

    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("hdr_metadata_frame_parser test passed");
    end else begin
      $display("hdr_metadata_frame_parser test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hmfp_pkg.sv
hw/rtl/hmfp_core.sv
hw/rtl/hmfp_result_fifo.sv
hw/rtl/hdr_metadata_frame_parser.sv
dv/tb_top.sv
